@@ rtl/core/iirl_pkg.sv @@
package iirl_pkg;

  localparam int unsigned CapacityDefault = 64;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OpAppend     = 3'd0,
    OpRemoveLast = 3'd1,
    OpInsert     = 3'd2,
    OpRemoveAt   = 3'd3,
    OpRead       = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StRange = 2'd3
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } iirl_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [CountW-1:0]       count;
    logic [StatusW-1:0]      status;
  } iirl_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic append_wr;
    logic ins_start;
    logic rem_start;
    logic read_issue;
    logic shift_step;
    logic last_wr;
    logic finish;
  } iirl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic ok;
    logic direct;
    logic step_last;
  } iirl_sts_t;

endpackage

@@ rtl/core/iirl_ram.sv @@
module iirl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/iirl_dp.sv @@
module iirl_dp import iirl_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iirl_req_t req_i,
  input  iirl_cmd_t cmd_i,
  output iirl_sts_t sts_o,
  output iirl_rsp_t rsp_o,
  output logic      done_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned CmpW  = ((CntW > PosW) ? CntW : PosW) + 1;

  logic [OpW-1:0]          op_q;
  logic [PosW-1:0]         pos_q;
  logic signed [DataW-1:0] val_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  iirl_rsp_t               rsp_q, rsp_d;
  logic                    done_q;

  logic [CmpW-1:0]  pos_x, cnt_x, idx_x, waddr_x;
  status_e          st;
  logic             is_ins;
  logic             direct, step_last;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.operation;
      pos_q <= req_i.position;
      val_q <= req_i.value;
    end
  end

  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(cnt_q);
  assign idx_x  = CmpW'(idx_q);
  assign is_ins = (op_q == OpInsert);

  always_comb begin
    st = StOk;
    unique case (op_q) inside
      OpAppend: begin
        if (cnt_x >= CmpW'(Capacity)) st = StFull;
      end
      OpRemoveLast: begin
        if (cnt_q == '0) st = StEmpty;
      end
      OpInsert: begin
        if (cnt_x >= CmpW'(Capacity)) st = StFull;
        else if (pos_x > cnt_x)        st = StRange;
      end
      OpRemoveAt, OpRead: begin
        if (cnt_q == '0)         st = StEmpty;
        else if (pos_x >= cnt_x) st = StRange;
      end
      default: st = StOk;
    endcase
  end

  assign direct    = is_ins ? (pos_x == cnt_x) : (pos_x + CmpW'(1) == cnt_x);
  assign step_last = is_ins ? (idx_x == pos_x + CmpW'(1)) : (idx_x + CmpW'(2) >= cnt_x);

  assign sts_o.op        = op_e'(op_q);
  assign sts_o.ok        = (st == StOk);
  assign sts_o.direct    = direct;
  assign sts_o.step_last = step_last;

  // shift index: insert walks down from count, remove walks up from position
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.ins_start) begin
      idx_d = AddrW'(cnt_q);
    end else if (cmd_i.rem_start) begin
      idx_d = AddrW'(pos_q);
    end else if (cmd_i.shift_step) begin
      idx_d = is_ins ? idx_q - AddrW'(1) : idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign ram_we    = cmd_i.append_wr | cmd_i.shift_step | cmd_i.last_wr;
  assign ram_waddr = cmd_i.append_wr  ? AddrW'(cnt_q) :
                     cmd_i.shift_step ? idx_q : AddrW'(pos_q);
  assign ram_wdata = cmd_i.shift_step ? ram_rdata : val_q;

  assign ram_re = cmd_i.read_issue | cmd_i.ins_start | cmd_i.rem_start |
                  (cmd_i.shift_step & ~step_last);

  always_comb begin
    if (cmd_i.read_issue) begin
      ram_raddr = AddrW'(pos_q);
    end else if (cmd_i.ins_start) begin
      ram_raddr = AddrW'(cnt_q - CntW'(1));
    end else if (cmd_i.rem_start) begin
      ram_raddr = AddrW'(pos_x + CmpW'(1));
    end else begin
      ram_raddr = is_ins ? idx_q - AddrW'(2) : idx_q + AddrW'(2);
    end
  end

  iirl_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish && st == StOk) begin
      case (op_q) inside
        OpAppend, OpInsert:       cnt_d = cnt_q + CntW'(1);
        OpRemoveLast, OpRemoveAt: cnt_d = cnt_q - CntW'(1);
        default:                  cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    rsp_d.read_value = ((op_q == OpRead) && (st == StOk)) ? signed'(ram_rdata) : '0;
    rsp_d.count      = CountW'(cnt_d);
    rsp_d.status     = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  assign waddr_x = CmpW'(ram_waddr);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= CmpW'(Capacity))
    else $error("fill count above capacity");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(cnt_q))
    else $error("fill count changed outside finish");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> waddr_x <= cnt_x)
    else $error("write beyond list end");

  a_rsp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_q.count == CountW'(cnt_q))
    else $error("reported count differs from fill count");
`endif

endmodule

@@ rtl/core/iirl_ctrl.sv @@
module iirl_ctrl import iirl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  iirl_sts_t sts_i,
  output iirl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    SIdle   = 5'b00001,
    SExec   = 5'b00010,
    SRdWait = 5'b00100,
    SShift  = 5'b01000,
    SLast   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SExec;
        end
      end
      SExec: begin
        state_d      = SIdle;
        cmd_o.finish = 1'b1;
        if (sts_i.ok) begin
          case (sts_i.op)
            OpAppend: cmd_o.append_wr = 1'b1;
            OpRead: begin
              cmd_o.read_issue = 1'b1;
              cmd_o.finish     = 1'b0;
              state_d          = SRdWait;
            end
            OpInsert: begin
              if (sts_i.direct) begin
                cmd_o.last_wr = 1'b1;
              end else begin
                cmd_o.ins_start = 1'b1;
                cmd_o.finish    = 1'b0;
                state_d         = SShift;
              end
            end
            OpRemoveAt: begin
              if (!sts_i.direct) begin
                cmd_o.rem_start = 1'b1;
                cmd_o.finish    = 1'b0;
                state_d         = SShift;
              end
            end
            default: ;
          endcase
        end
      end
      SRdWait: begin
        cmd_o.finish = 1'b1;
        state_d      = SIdle;
      end
      SShift: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.step_last) begin
          if (sts_i.op == OpInsert) begin
            state_d = SLast;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = SIdle;
          end
        end
      end
      SLast: begin
        cmd_o.last_wr = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != SIdle);

endmodule

@@ rtl/core/indexed_insert_remove_list.sv @@
// Ordered list of signed 32-bit values with append, remove last, insert at
// index, remove at index and read at index.
// Input: an item (req_i) is taken at a clock edge where start is high and
// busy is low. Output: one result item per input item on rsp_o, shown for
// exactly one cycle while done_o is high; the receiver cannot stall it.
// Steps from the accepting edge to the done_o cycle: append, remove last,
//   failed ops, insert at the end and remove of the last entry finish in
//   the execute state; read adds a read-wait state; insert moves
//   n = count - position entries in the shift state, then writes the value
//   in the last state; remove at moves n = count - position - 1 entries.
// Entries move one per cycle through the single-port-pair entry RAM, which
// sets the shift time. The next item is accepted in the cycle its
// predecessor's result is shown.
// Reset clears the count and the controller; the entry RAM is not cleared
// and needs no clearing pass, since only entries below the count are read.
module indexed_insert_remove_list import iirl_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  iirl_req_t req_i,
  output iirl_rsp_t rsp_o,
  output logic      done_o
);

  iirl_cmd_t cmd;
  iirl_sts_t sts;

  iirl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  iirl_dp #(
    .Capacity (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule
